/* design/bsbn_pkg.sv */
// shared types, codes and constants for the bayer superpixel binning unit
// no dependencies; compiled before every other file of the block
package bsbn_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 16;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int MASK_W     = 2;
  localparam int VAL_W      = 18;
  localparam int NORM_STEPS = 8;

  // transfer op codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK_EE      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK_EO      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK_OE      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK_OO      = 3'd5;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 10'd512;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 10'd512;

  // channel codes
  localparam logic [MASK_W-1:0] CH_RED   = 2'd0;
  localparam logic [MASK_W-1:0] CH_GREEN = 2'd1;
  localparam logic [MASK_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [MASK_W-1:0] CH_NONE  = 2'd3;

  localparam logic [VAL_W-1:0] VAL_POS_MAX = 18'h1ffff;
  localparam logic [VAL_W-1:0] VAL_NEG_MAX = 18'h20000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_LDIV,
    ST_LADDR,
    ST_LREAD,
    ST_LWRITE,
    ST_NLOAD,
    ST_NDIV,
    ST_NSTORE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    NRM_DIV,
    NRM_ZERO,
    NRM_SAT
  } nrm_mode_t;

  typedef struct packed {
    logic              accept;
    logic              clr_init;
    logic              clr_step;
    logic              load_div_start;
    logic              div_step;
    logic              addr_calc;
    logic              ld_read;
    logic              ld_write;
    logic              rd_issue;
    logic              norm_start;
    logic              norm_store;
    logic [MASK_W-1:0] nch;
    logic              out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_full;
    logic cells_zero;
    logic div_last;
    logic mask_none;
    logic clr_last;
  } ctrl_sts_t;

endpackage

/* design/bsbn_in_if.sv */
// input channel: op and raw sample with valid/ready
// depends on bsbn_pkg
interface bsbn_in_if;
  import bsbn_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

/* design/bsbn_out_if.sv */
// output channel: one normalized superpixel with valid/ready
// depends on bsbn_pkg
interface bsbn_out_if;
  import bsbn_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             last;
  modport source (output valid, output red, output green, output blue, output last,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input last,
                output ready);
endinterface

/* design/bsbn_dp.sv */
// datapath: config registers, channel store, shared restoring divider, min/max
// depends on bsbn_pkg; driven by bsbn_ctrl through command and status structs
module bsbn_dp #(
  parameter int MAX_WIDTH  = bsbn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bsbn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bsbn_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bsbn_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [bsbn_pkg::SAMPLE_W-1:0] sample,
  input  bsbn_pkg::ctrl_cmd_t                  cmd,
  output bsbn_pkg::ctrl_sts_t                  sts,
  output logic [bsbn_pkg::PIX_W-1:0]           red,
  output logic [bsbn_pkg::PIX_W-1:0]           green,
  output logic [bsbn_pkg::PIX_W-1:0]           blue,
  output logic                                 last
);
  import bsbn_pkg::*;

  localparam int CFG_EVEN_MAX = (1 << CFG_W) - 2;
  localparam int MW_EVEN  = (MAX_WIDTH / 2) * 2;
  localparam int MH_EVEN  = (MAX_HEIGHT / 2) * 2;
  localparam int EW_MAX   = (MW_EVEN < CFG_EVEN_MAX) ? MW_EVEN : CFG_EVEN_MAX;
  localparam int EH_MAX   = (MH_EVEN < CFG_EVEN_MAX) ? MH_EVEN : CFG_EVEN_MAX;
  localparam int CNT_W    = $clog2(EW_MAX * EH_MAX + 1);
  localparam int Q_W      = (CNT_W > NORM_STEPS) ? CNT_W : NORM_STEPS;
  localparam int DC_W     = $clog2(Q_W + 1);
  localparam int CELLS    = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CELLS_W  = $clog2(CELLS + 1);
  localparam int PROD_W   = Q_W + CFG_W;

  // config registers
  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [MASK_W-1:0] mask [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      mask[0]      <= CH_RED;
      mask[1]      <= CH_GREEN;
      mask[2]      <= CH_GREEN;
      mask[3]      <= CH_BLUE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_MASK_EE:      mask[0]      <= cfg_data[MASK_W-1:0];
        REG_MASK_EO:      mask[1]      <= cfg_data[MASK_W-1:0];
        REG_MASK_OE:      mask[2]      <= cfg_data[MASK_W-1:0];
        REG_MASK_OO:      mask[3]      <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: even, limited by the store
  logic [CFG_W-1:0] w_even, h_even, eff_w, eff_h;
  assign w_even = {frame_width[CFG_W-1:1], 1'b0};
  assign h_even = {frame_height[CFG_W-1:1], 1'b0};
  assign eff_w  = (32'(w_even) > 32'(MW_EVEN)) ? CFG_W'(MW_EVEN) : w_even;
  assign eff_h  = (32'(h_even) > 32'(MH_EVEN)) ? CFG_W'(MH_EVEN) : h_even;

  logic [CNT_W-1:0]           total, count;
  logic [CELLS_W-1:0]         cells;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [ADDR_W-1:0]          idx, clr_addr, cell_addr;
  logic [MASK_W-1:0]          wch;
  logic [VAL_W-1:0]           min_v, max_v;

  // divider
  logic [VAL_W-1:0] rem, dvs;
  logic [Q_W-1:0]   quo;
  logic [DC_W-1:0]  dcnt;
  logic [VAL_W:0]   sh;
  logic             ge;
  assign sh = {rem, quo[Q_W-1]};
  assign ge = sh >= {1'b0, dvs};

  // store
  logic [VAL_W-1:0] mem_r [CELLS];
  logic [VAL_W-1:0] mem_g [CELLS];
  logic [VAL_W-1:0] mem_b [CELLS];
  logic [VAL_W-1:0] q_r, q_g, q_b;

  logic [ADDR_W-1:0] eff_idx, rd_addr, wr_addr;
  logic              rd_en;
  logic [2:0]        wr_en;
  logic [VAL_W-1:0]  wr_data, new_v;
  logic signed [SAMPLE_W:0] s_adj, half;

  assign eff_idx = (CELLS_W'(idx) >= cells) ? '0 : idx;
  assign rd_en   = cmd.ld_read | cmd.rd_issue;
  assign rd_addr = cmd.rd_issue ? eff_idx : cell_addr;
  assign wr_addr = cmd.clr_step ? clr_addr : cell_addr;

  // half of a sample, truncated toward zero
  assign s_adj = $signed({sample_q[SAMPLE_W-1], sample_q})
               + $signed({{SAMPLE_W{1'b0}}, sample_q[SAMPLE_W-1]});
  assign half  = s_adj >>> 1;
  assign new_v = (wch == CH_GREEN) ? q_g + {half[SAMPLE_W], half}
                                   : {{(VAL_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
  assign wr_data = cmd.clr_step ? '0 : new_v;

  always_comb begin
    wr_en[0] = cmd.clr_step | (cmd.ld_write & (wch == CH_RED));
    wr_en[1] = cmd.clr_step | (cmd.ld_write & (wch == CH_GREEN));
    wr_en[2] = cmd.clr_step | (cmd.ld_write & (wch == CH_BLUE));
  end

  always_ff @(posedge clk) begin
    if (wr_en[0]) mem_r[wr_addr] <= wr_data;
    if (wr_en[1]) mem_g[wr_addr] <= wr_data;
    if (wr_en[2]) mem_b[wr_addr] <= wr_data;
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
      q_g <= mem_g[rd_addr];
      q_b <= mem_b[rd_addr];
    end
  end

  // cell position of the divided sample count
  logic [MASK_W-1:0] chsel;
  logic [PROD_W-1:0] cell_full;
  assign chsel     = mask[{quo[0], rem[0]}];
  assign cell_full = PROD_W'(quo[Q_W-1:1]) * PROD_W'(eff_w[CFG_W-1:1])
                   + PROD_W'(rem[CFG_W-1:1]);

  // normalization operand selection
  logic [VAL_W-1:0] nv;
  logic [VAL_W:0]   dlt;
  logic             dpos;
  nrm_mode_t        nmode;
  logic [PIX_W-1:0] nres, res_r, res_g, res_b;

  always_comb begin
    case (cmd.nch)
      CH_RED:   nv = q_r;
      CH_GREEN: nv = q_g;
      default:  nv = q_b;
    endcase
  end
  assign dlt  = {max_v[VAL_W-1], max_v} - {min_v[VAL_W-1], min_v};
  assign dpos = !dlt[VAL_W] && (dlt != '0);

  always_comb begin
    case (nmode)
      NRM_ZERO: nres = '0;
      NRM_SAT:  nres = '1;
      default:  nres = quo[PIX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
      total    <= CNT_W'(eff_w * eff_h);
      cells    <= CELLS_W'(eff_w[CFG_W-1:1] * eff_h[CFG_W-1:1]);
    end
    if (cmd.load_div_start) begin
      rem  <= '0;
      quo  <= Q_W'(count);
      dvs  <= VAL_W'(eff_w);
      dcnt <= DC_W'(Q_W);
    end else if (cmd.norm_start) begin
      rem  <= nv;
      quo  <= '0;
      dvs  <= dlt[VAL_W-1:0];
      dcnt <= DC_W'(NORM_STEPS);
      if (!dpos || nv[VAL_W-1]) nmode <= NRM_ZERO;
      else if ({1'b0, nv} >= dlt) nmode <= NRM_SAT;
      else nmode <= NRM_DIV;
    end else if (cmd.div_step) begin
      rem  <= ge ? VAL_W'(sh - {1'b0, dvs}) : sh[VAL_W-1:0];
      quo  <= {quo[Q_W-2:0], ge};
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.addr_calc) begin
      cell_addr <= ADDR_W'(cell_full);
      wch       <= chsel;
    end
    if (cmd.norm_store) begin
      case (cmd.nch)
        CH_RED:   res_r <= nres;
        CH_GREEN: res_g <= nres;
        default:  res_b <= nres;
      endcase
    end
    if (cmd.out_load) begin
      red   <= res_r;
      green <= res_g;
      blue  <= res_b;
      last  <= CELLS_W'(idx) == cells - 1'b1;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) begin
      count    <= '0;
      idx      <= '0;
      clr_addr <= '0;
      min_v    <= VAL_POS_MAX;
      max_v    <= VAL_NEG_MAX;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.addr_calc) count <= count + 1'b1;
      if (cmd.rd_issue) idx <= eff_idx;
      if (cmd.out_load)
        idx <= (CELLS_W'(idx) + 1'b1 >= cells) ? '0 : idx + 1'b1;
      if (cmd.ld_write) begin
        if ($signed(new_v) > $signed(max_v)) max_v <= new_v;
        if ($signed(new_v) < $signed(min_v)) min_v <= new_v;
      end
    end
  end

  always_comb begin
    sts.count_full = count >= total;
    sts.cells_zero = cells == '0;
    sts.div_last   = dcnt == DC_W'(1);
    sts.mask_none  = chsel == CH_NONE;
    sts.clr_last   = clr_addr == ADDR_W'(CELLS - 1);
  end

endmodule

/* design/bsbn_ctrl.sv */
// controller: sequences clear, load, readout and output transfer
// depends on bsbn_pkg; commands bsbn_dp through command and status structs
module bsbn_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [bsbn_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bsbn_pkg::ctrl_cmd_t       cmd,
  input  bsbn_pkg::ctrl_sts_t       sts
);
  import bsbn_pkg::*;

  state_t            state, state_next;
  logic [OP_W-1:0]   op_q;
  logic [MASK_W-1:0] nch, nch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      nch       <= CH_RED;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      nch   <= nch_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) op_q <= in_op;
  end

  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    nch_next   = nch;
    cmd        = '0;
    cmd.nch    = nch;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (op_q)
          OP_LOAD: begin
            if (sts.count_full) state_next = ST_IDLE;
            else begin
              cmd.load_div_start = 1'b1;
              state_next         = ST_LDIV;
            end
          end
          OP_READ: begin
            if (sts.cells_zero) state_next = ST_IDLE;
            else begin
              cmd.rd_issue = 1'b1;
              nch_next     = CH_RED;
              state_next   = ST_NLOAD;
            end
          end
          OP_START: begin
            cmd.clr_init = 1'b1;
            state_next   = ST_CLEAR;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_LDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_LADDR;
      end
      ST_LADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = sts.mask_none ? ST_IDLE : ST_LREAD;
      end
      ST_LREAD: begin
        cmd.ld_read = 1'b1;
        state_next  = ST_LWRITE;
      end
      ST_LWRITE: begin
        cmd.ld_write = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_NLOAD: begin
        cmd.norm_start = 1'b1;
        state_next     = ST_NDIV;
      end
      ST_NDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_NSTORE;
      end
      ST_NSTORE: begin
        cmd.norm_store = 1'b1;
        if (nch == CH_BLUE) state_next = ST_OUT;
        else begin
          nch_next   = nch + 1'b1;
          state_next = ST_NLOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/bayer_superpixel_bin_normalize_unit.sv */
// top level of the bayer 2x2 superpixel binning and normalization unit
// depends on bsbn_pkg, bsbn_in_if, bsbn_out_if, bsbn_ctrl and bsbn_dp
//
// Raw signed samples arrive in raster order (op load) and are binned into one
// three-channel superpixel per 2x2 cell; the four mask registers pick the
// channel of each cell position, the green channel accumulates half of each
// sample (truncated toward zero, wrapping at 18 bits) while red and blue
// overwrite, and a code of 3 drops the sample. A global min and max follow
// every stored value. A read op returns the next superpixel with each channel
// scaled as value*256/(max-min), clamped to 0..255 (0 when the span is not
// positive), and last on the final superpixel; reads wrap and do not wait for
// a full frame. A start op clears the store. One item is worked on at a time.
// A load splits its sample count into row and column one bit a cycle through
// the shared restoring divider, over the sample-count width (19 bits at the
// default 512x512); a load past the end of the frame, a read of an empty
// frame and the unused op do nothing. A read runs three channels of eight
// divider steps each and waits while the previous superpixel still sits in
// the output register. A start sweeps the store clear, one entry per cycle,
// and after reset the same sweep runs with the input held off (config writes
// are always taken).
// A finished superpixel sits in an output register, so the next item is taken
// while it waits for its transfer. Config writes are expected only when idle.
module bayer_superpixel_bin_normalize_unit #(
  parameter int MAX_WIDTH  = bsbn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bsbn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // register write port
  input  logic                            cfg_we,
  input  logic [bsbn_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bsbn_pkg::CFG_W-1:0]      cfg_data,
  // raw sample / op transfers in, superpixel transfers out
  bsbn_in_if.sink                         raw,
  bsbn_out_if.source                      pix
);
  import bsbn_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencing and handshake
  bsbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (raw.valid),
    .in_op     (raw.op),
    .in_ready  (raw.ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // store, divider and output payload
  bsbn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .sample   (raw.sample),
    .cmd      (cmd),
    .sts      (sts),
    .red      (pix.red),
    .green    (pix.green),
    .blue     (pix.blue),
    .last     (pix.last)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// testbench of bayer_superpixel_bin_normalize_unit: raw sample, read and start
// transfers with a predictor of binning and normalization
// depends on bsbn_pkg, bsbn_in_if, bsbn_out_if and the unit itself
module tb;
  import bsbn_pkg::*;

  localparam int CELLS      = (DEF_MAX_WIDTH / 2) * (DEF_MAX_HEIGHT / 2);
  localparam int IDLE_LIMIT = 200000;
  localparam int LONG_HOLD  = 400;

  typedef struct {
    logic [OP_W-1:0]            op;
    logic signed [SAMPLE_W-1:0] sample;
  } raw_item_t;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } superpixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bsbn_in_if  raw ();
  bsbn_out_if pix ();

  bayer_superpixel_bin_normalize_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .raw(raw.sink), .pix(pix.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the register file
  int unsigned width_reg  = RST_FRAME_WIDTH;
  int unsigned height_reg = RST_FRAME_HEIGHT;
  int unsigned mask_reg [4] = '{0, 1, 1, 2};

  // predictor copy of the binning state
  int           red_bins   [CELLS];
  int           green_bins [CELLS];
  int           blue_bins  [CELLS];
  int unsigned  samples_in;
  int unsigned  next_cell;
  int           lo_value;
  int           hi_value;

  raw_item_t    pending_raw [$];
  superpixel_t  expected_pix [$];

  int  errors = 0;
  int  n_loads = 0, n_reads = 0, n_starts = 0, n_pix = 0;
  bit  quiet_sender = 0, quiet_receiver = 0;
  bit  hold_go = 0;

  function automatic int unsigned frame_dim(int unsigned r);
    int unsigned v;
    v = r & ~32'd1;
    return (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : v;
  endfunction

  function automatic int wrap_to_18(int x);
    logic [VAL_W-1:0] t;
    t = x[VAL_W-1:0];
    return int'(signed'(t));
  endfunction

  function automatic logic [PIX_W-1:0] scale_channel(int v, longint span);
    longint q;
    if (span <= 0) return '0;
    q = (longint'(v) * 256) / span;
    if (q < 0) return '0;
    if (q > 255) return 8'd255;
    return q[PIX_W-1:0];
  endfunction

  function automatic void wipe_frame();
    for (int i = 0; i < CELLS; i++) begin
      red_bins[i] = 0;
      green_bins[i] = 0;
      blue_bins[i] = 0;
    end
    samples_in = 0;
    next_cell = 0;
    lo_value = 131071;
    hi_value = -131072;
  endfunction

  // work out the effect of one accepted transfer and queue any superpixel
  function automatic void bin_and_predict(raw_item_t it);
    int unsigned w, h, cells, row, col, bin_idx, ch;
    int s, v;
    longint span;
    superpixel_t px;
    w = frame_dim(width_reg);
    h = frame_dim(height_reg);
    cells = (w / 2) * (h / 2);
    case (it.op)
      OP_LOAD: begin
        n_loads++;
        if (samples_in >= w * h) return;
        row = samples_in / w;
        col = samples_in % w;
        samples_in++;
        ch = mask_reg[{row[0], col[0]}];
        if (ch > CH_BLUE) return;
        bin_idx = (row >> 1) * (w >> 1) + (col >> 1);
        s = it.sample;
        if (ch == CH_GREEN) begin
          green_bins[bin_idx] = wrap_to_18(green_bins[bin_idx] + s / 2);
          v = green_bins[bin_idx];
        end else if (ch == CH_RED) begin
          red_bins[bin_idx] = s;
          v = s;
        end else begin
          blue_bins[bin_idx] = s;
          v = s;
        end
        if (v > hi_value) hi_value = v;
        if (v < lo_value) lo_value = v;
      end
      OP_READ: begin
        n_reads++;
        if (cells == 0) return;
        if (next_cell >= cells) next_cell = 0;
        span = longint'(hi_value) - longint'(lo_value);
        px.red   = scale_channel(red_bins[next_cell], span);
        px.green = scale_channel(green_bins[next_cell], span);
        px.blue  = scale_channel(blue_bins[next_cell], span);
        px.last  = (next_cell == cells - 1);
        expected_pix.push_back(px);
        next_cell = (next_cell + 1 >= cells) ? 0 : next_cell + 1;
      end
      OP_START: begin
        n_starts++;
        wipe_frame();
      end
      default: ;
    endcase
  endfunction

  // driver: one transfer at a time from the pending queue, random gaps
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    raw_item_t it;
    if (rst) begin
      raw.valid <= 1'b0;
    end else begin
      if (raw.valid && raw.ready)
        bin_and_predict('{op: raw.op, sample: raw.sample});
      if (!raw.valid || raw.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          raw.valid <= 1'b0;
        end else if (pending_raw.size() > 0) begin
          it = pending_raw.pop_front();
          raw.op <= it.op;
          raw.sample <= it.sample;
          raw.valid <= 1'b1;
          send_gap <= quiet_sender ? 0 : $urandom_range(0, 9);
        end else begin
          raw.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each superpixel transfer with the oldest expectation
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    superpixel_t want;
    if (!rst) begin
      if (pix.valid && pix.ready) begin
        n_pix++;
        if (expected_pix.size() == 0) begin
          $error("superpixel transfer with nothing expected");
          errors++;
        end else begin
          want = expected_pix.pop_front();
          if (pix.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, pix.red);
            errors++;
          end
          if (pix.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, pix.green);
            errors++;
          end
          if (pix.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, pix.blue);
            errors++;
          end
          if (pix.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, pix.last);
            errors++;
          end
        end
      end
      // long hold-off so the output register fills and the input stalls
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        pix.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pix.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= 1'b1;
        if (pix.valid && pix.ready)
          recv_stall <= quiet_receiver ? 0 : $urandom_range(0, 9);
      end
    end
  end

  // watchdog on cycles with no transfer and no register write
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((raw.valid && raw.ready) || (pix.valid && pix.ready) || cfg_we || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic push_op(logic [OP_W-1:0] op, int s = 0);
    raw_item_t it;
    it.op = op;
    it.sample = s[SAMPLE_W-1:0];
    pending_raw.push_back(it);
  endtask

  function automatic int draw_sample(bit narrow);
    case ($urandom_range(0, 9))
      0: return 32767;
      1: return -32768;
      default: return narrow ? int'($urandom_range(0, 400)) - 100
                             : int'(signed'(16'($urandom)));
    endcase
  endfunction

  // one register write per cycle; the caller lowers the enable afterwards
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      default:          mask_reg[idx - REG_MASK_EE] = val[MASK_W-1:0];
    endcase
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, bit rand_masks);
    write_reg(REG_FRAME_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    for (int i = 0; i < 4; i++)
      write_reg(CFG_ADDR_W'(REG_MASK_EE + i),
                {8'($urandom), rand_masks ? 2'($urandom) : 2'((i + 1) >> 1)});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender pause until every expected superpixel is in, then let the
  // block finish a trailing load or read before registers change
  task automatic drain();
    while (pending_raw.size() > 0 || raw.valid || send_gap > 0 || expected_pix.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // start, a run of loads with reads and unused ops mixed in, then a readout pass
  task automatic frame_phase(int unsigned loads, int unsigned reads, bit narrow);
    push_op(OP_START);
    for (int i = 0; i < loads; i++) begin
      push_op(OP_LOAD, draw_sample(narrow));
      if ($urandom_range(0, 15) == 0) push_op(OP_READ);
      if ($urandom_range(0, 60) == 0) push_op(OP_UNUSED);
    end
    for (int i = 0; i < reads; i++)
      push_op(OP_READ);
  endtask

  initial begin
    int unsigned w, h;
    raw.valid = 1'b0;
    raw.op = OP_LOAD;
    raw.sample = '0;
    pix.ready = 1'b0;
    wipe_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, field extremes, unused op, mask code 3, start
    push_op(OP_READ);
    push_op(OP_UNUSED);
    push_op(OP_LOAD, 32767);
    push_op(OP_LOAD, -32768);
    push_op(OP_LOAD, -1);
    push_op(OP_LOAD, 1);
    push_op(OP_LOAD, 16'sh5555);
    push_op(OP_LOAD, -21846);
    push_op(OP_READ);
    push_op(OP_READ);
    drain();
    set_frame(2, 2, 0);
    write_reg(REG_MASK_OO, CFG_W'(CH_NONE));
    @(posedge clk);
    cfg_we <= 1'b0;
    push_op(OP_START);
    push_op(OP_READ);
    push_op(OP_LOAD, 100);
    push_op(OP_LOAD, 50);
    push_op(OP_LOAD, -50);
    push_op(OP_LOAD, 7);
    push_op(OP_LOAD, 9);
    push_op(OP_READ);
    push_op(OP_READ);
    drain();

    // size of zero: loads and reads are ignored
    set_frame(1, 4, 1);
    push_op(OP_START);
    push_op(OP_LOAD, 5);
    push_op(OP_READ);
    push_op(OP_LOAD, 6);
    push_op(OP_READ);
    drain();

    // widest frame, width register above the limit, partly filled
    set_frame(1023, 2, 0);
    frame_phase(300, 40, 0);
    drain();

    // long receiver hold-off with reads queued behind it
    set_frame(4, 3, 0);
    push_op(OP_START);
    for (int i = 0; i < 8; i++) push_op(OP_LOAD, draw_sample(1));
    drain();
    hold_go = 1;
    for (int i = 0; i < 30; i++) push_op(OP_READ);
    drain();

    // random small frames and a tall narrow one, one with no idling on either side
    for (int p = 0; p < 5; p++) begin
      w = (p == 4) ? 2 : 2 * $urandom_range(1, 8) + $urandom_range(0, 1);
      h = 2 * $urandom_range(1, 8) + $urandom_range(0, 1);
      quiet_sender = (p == 2);
      quiet_receiver = (p == 2);
      set_frame(w, (p == 4) ? 513 : h, p != 0);
      if (p == 4)
        frame_phase(120, 70, 0);
      else
        frame_phase(frame_dim(w) * frame_dim(h) + $urandom_range(0, 4),
                    (frame_dim(w) * frame_dim(h)) / 4 + $urandom_range(1, 8), p[0]);
      drain();
    end

    // a partial frame, then a size shrink in mid-frame with extra samples past the end
    set_frame(6, 6, 1);
    frame_phase(20, 3, 1);
    drain();
    set_frame(4, 4, 1);
    for (int i = 0; i < 6; i++) push_op(OP_LOAD, draw_sample(0));
    for (int i = 0; i < 6; i++) push_op(OP_READ);
    drain();

    $display("tb: %0d loads, %0d reads, %0d starts, %0d superpixels checked",
             n_loads, n_reads, n_starts, n_pix);
    $display("tb: frames from 2x2 to 512x2, zero size, all mask codes, long output stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
